### rtl/afp_pkg.sv
// Package for the audio frame preconditioner: constants, payload types and register codes.
package afp_pkg;

    localparam int FRAME_DEPTH = 4096;
    localparam int ADDR_W = $clog2(FRAME_DEPTH);
    localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
    localparam int SUM_W = 32 + CNT_W;

    localparam logic [2:0] REG_SAMPLE_BITS = 3'd0;
    localparam logic [2:0] REG_DC_ENABLE = 3'd1;
    localparam logic [2:0] REG_HP_ENABLE = 3'd2;
    localparam logic [2:0] REG_HP_COEFF = 3'd3;
    localparam logic [2:0] REG_NORM_ENABLE = 3'd4;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_WIDTH = 2'd1;
    localparam logic [1:0] STATUS_CAPACITY = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [31:0] raw_sample;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] sample;
        logic               final_res;
        logic [1:0]         status;
        logic [12:0]        frame_length;
    } out_item_t;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic signed [63:0] dividend;
        logic [63:0]        divisor;
    } div_req_t;

    // Answer from the shared divider.
    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] quotient;
    } div_rsp_t;

endpackage

### rtl/audio_frame_preconditioner.sv
// Top level of the audio frame preconditioner: sequencer, registers and port logic.
// A load not marked last passes through S_LOADW; a read passes S_READW and S_READO to its result strobe.
// The last load runs the passes: mean removal, the high-pass and peak search, with a divide
// on the shared divider for the mean; normalization divides each sample by the peak.
// busy stays high for the whole of that work; the receiver cannot stall results.
// Reset (rst_n, asynchronous) loads register defaults and opens an empty frame.
module audio_frame_preconditioner (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  afp_pkg::in_item_t   in_item,
    output logic                result_valid,
    output afp_pkg::out_item_t  result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LOADW   = 4'd1;
    localparam logic [3:0] S_READW   = 4'd2;
    localparam logic [3:0] S_READO   = 4'd3;
    localparam logic [3:0] S_MEAN    = 4'd4;
    localparam logic [3:0] S_DCRD    = 4'd5;
    localparam logic [3:0] S_DCWR    = 4'd6;
    localparam logic [3:0] S_HPRD    = 4'd7;
    localparam logic [3:0] S_HPWR    = 4'd8;
    localparam logic [3:0] S_PKRD    = 4'd9;
    localparam logic [3:0] S_PKCMP   = 4'd10;
    localparam logic [3:0] S_NMRD    = 4'd11;
    localparam logic [3:0] S_NMDIV   = 4'd12;
    localparam logic [3:0] S_NMWR    = 4'd13;
    localparam logic [3:0] S_STATUS  = 4'd14;
    localparam logic [3:0] S_HPMUL   = 4'd15;

    localparam int AW = afp_pkg::ADDR_W;
    localparam int CW = afp_pkg::CNT_W;
    localparam int SW = afp_pkg::SUM_W;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  bits_reg;
    logic        dc_en_reg, hp_en_reg, nm_en_reg;
    logic [15:0] coeff_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]  err_reg, err_next;
    logic        closed_reg, closed_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [31:0] mean_reg, mean_next;
    logic signed [31:0] px_reg, px_next;
    logic signed [31:0] py_reg, py_next;
    logic [31:0] peak_reg, peak_next;
    logic signed [48:0] prod_reg, prod_next;
    logic signed [31:0] x_reg, x_next;
    logic        res_v_reg, res_v_next;
    afp_pkg::out_item_t res_reg, res_next;

    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0] ram_wdata, ram_rdata;
    afp_pkg::div_req_t dreq;
    afp_pkg::div_rsp_t drsp;

    logic        accept;
    logic        dec_ok;
    logic signed [31:0] dec_val;
    logic signed [32:0] dc_diff;
    logic signed [33:0] hp_d;
    logic signed [50:0] hp_mul;
    logic signed [48:0] hp_sh;
    logic signed [31:0] sv;
    logic [31:0] absv;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    logic [1:0]  stat_code;

    afp_ram #(.WIDTH(32), .DEPTH(afp_pkg::FRAME_DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    afp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Register port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_comb
    begin
        unique case (cfg_idx)
            afp_pkg::REG_SAMPLE_BITS: prdata = {26'd0, bits_reg};
            afp_pkg::REG_DC_ENABLE:   prdata = {31'd0, dc_en_reg};
            afp_pkg::REG_HP_ENABLE:   prdata = {31'd0, hp_en_reg};
            afp_pkg::REG_HP_COEFF:    prdata = {16'd0, coeff_reg};
            afp_pkg::REG_NORM_ENABLE: prdata = {31'd0, nm_en_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= 6'd16;
            dc_en_reg <= 1'b1;
            hp_en_reg <= 1'b1;
            coeff_reg <= 16'd65208;
            nm_en_reg <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                afp_pkg::REG_SAMPLE_BITS: bits_reg <= pwdata[5:0];
                afp_pkg::REG_DC_ENABLE:   dc_en_reg <= pwdata[0];
                afp_pkg::REG_HP_ENABLE:   hp_en_reg <= pwdata[0];
                afp_pkg::REG_HP_COEFF:    coeff_reg <= pwdata[15:0];
                afp_pkg::REG_NORM_ENABLE: nm_en_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Sample decode: place the signed sample at the top and shift down arithmetically.
    // For 8-bit samples the offset of 128 is removed by flipping the top bit.
    always_comb
    begin
        dec_ok = 1'b1;
        unique case (bits_reg)
            6'd8:  dec_val = $signed({~in_item.raw_sample[7], in_item.raw_sample[6:0],
                                      24'd0}) >>> 3;
            6'd16: dec_val = $signed({in_item.raw_sample[15:0], 16'd0}) >>> 3;
            6'd24: dec_val = $signed({in_item.raw_sample[23:0], 8'd0}) >>> 3;
            6'd32: dec_val = $signed(in_item.raw_sample) >>> 3;
            default:
            begin
                dec_val = '0;
                dec_ok = 1'b0;
            end
        endcase
    end

    assign accept = start && !busy;
    assign busy = (state_reg != S_IDLE);
    assign sv = $signed(ram_rdata);
    assign absv = sv[31] ? 32'(-sv) : 32'(sv);
    assign dc_diff = 33'(sv) - 33'(mean_reg);
    assign hp_d = 34'(py_reg) + 34'(sv) - 34'(px_reg);
    assign hp_mul = 51'(hp_d) * 51'($signed({1'b0, coeff_reg}));
    assign hp_sh = prod_reg >>> 16;
    assign stat_code = err_reg[0] ? afp_pkg::STATUS_WIDTH :
                       (err_reg[1] ? afp_pkg::STATUS_CAPACITY : afp_pkg::STATUS_OK);

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647) r = 32'sh7fffffff;
        else if (v < -50'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rptr_next = rptr_reg;
        idx_next = idx_reg;
        err_next = err_reg;
        closed_next = closed_reg;
        sum_next = sum_reg;
        mean_next = mean_reg;
        px_next = px_reg;
        py_next = py_reg;
        peak_next = peak_reg;
        prod_next = prod_reg;
        x_next = x_reg;
        res_v_next = 1'b0;
        res_next = res_reg;
        ram_we = 1'b0;
        ram_addr = idx_reg[AW-1:0];
        ram_wdata = '0;
        dreq = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !in_item.mode)
                begin
                    if (closed_reg)
                    begin
                        count_next = '0;
                        sum_next = '0;
                        err_next = '0;
                        rptr_next = '0;
                        closed_next = 1'b0;
                    end
                    if (!dec_ok)
                    begin
                        err_next[0] = 1'b1;
                    end
                    if ((closed_reg ? CW'(0) : count_reg) < CW'(afp_pkg::FRAME_DEPTH))
                    begin
                        ram_we = 1'b1;
                        ram_addr = closed_reg ? '0 : count_reg[AW-1:0];
                        ram_wdata = dec_val;
                        count_next = (closed_reg ? CW'(0) : count_reg) + CW'(1);
                        sum_next = (closed_reg ? SW'(0) : sum_reg) + SW'(dec_val);
                    end
                    else
                    begin
                        err_next[1] = 1'b1;
                    end
                    x_next = {31'd0, in_item.last};
                    state_next = S_LOADW;
                end
                else if (accept && in_item.mode)
                begin
                    if (closed_reg && rptr_reg < count_reg)
                    begin
                        ram_addr = rptr_reg[AW-1:0];
                        state_next = S_READW;
                    end
                end
            end
            S_LOADW:
            begin
                if (!x_reg[0])
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    closed_next = 1'b1;
                    rptr_next = '0;
                    idx_next = '0;
                    if (err_reg[0])
                    begin
                        count_next = '0;
                        state_next = S_STATUS;
                    end
                    else if (dc_en_reg)
                    begin
                        dreq.start = 1'b1;
                        dreq.dividend = 64'(sum_reg);
                        dreq.divisor = 64'(count_reg);
                        state_next = S_MEAN;
                    end
                    else
                    begin
                        state_next = S_DCWR;
                    end
                end
            end
            S_READW:
            begin
                ram_addr = rptr_reg[AW-1:0];
                state_next = S_READO;
            end
            S_READO:
            begin
                res_v_next = 1'b1;
                res_next.kind = 1'b1;
                res_next.sample = sv;
                res_next.final_res = (rptr_reg + CW'(1) == count_reg);
                res_next.status = afp_pkg::STATUS_OK;
                res_next.frame_length = 13'(count_reg);
                rptr_next = rptr_reg + CW'(1);
                state_next = S_IDLE;
            end
            S_MEAN:
            begin
                if (drsp.done)
                begin
                    mean_next = 32'(drsp.quotient);
                    idx_next = '0;
                    state_next = S_DCRD;
                end
            end
            S_DCRD:
            begin
                state_next = S_DCWR;
                x_next = 32'(1);
            end
            S_DCWR:
            begin
                // Mean subtraction, one sample per read/write pair; also pass-done hop.
                if (dc_en_reg && x_reg == 32'(1))
                begin
                    ram_we = 1'b1;
                    ram_wdata = sat32(50'(dc_diff));
                    x_next = '0;
                    if (idx_reg + CW'(1) < count_reg)
                    begin
                        idx_next = idx_reg + CW'(1);
                        state_next = S_DCRD;
                    end
                    else
                    begin
                        idx_next = '0;
                    end
                end
                else
                begin
                    x_next = '0;
                    idx_next = '0;
                    if (hp_en_reg && coeff_reg != 16'd0)
                    begin
                        state_next = S_HPRD;
                    end
                    else if (nm_en_reg)
                    begin
                        peak_next = '0;
                        state_next = S_PKRD;
                    end
                    else
                    begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_HPRD:
            begin
                state_next = S_HPMUL;
            end
            S_HPMUL:
            begin
                if (idx_reg == '0)
                begin
                    px_next = sv;
                    py_next = sv;
                    state_next = S_HPWR;
                end
                else
                begin
                    prod_next = hp_mul[48:0];
                    x_next = sv;
                    state_next = S_HPWR;
                end
            end
            S_HPWR:
            begin
                // The write goes back to the sample just read; the next read is issued in S_HPRD.
                if (idx_reg != '0)
                begin
                    ram_we = 1'b1;
                    ram_wdata = sat32(50'(hp_sh));
                    px_next = x_reg;
                    py_next = sat32(50'(hp_sh));
                end
                if (idx_reg + CW'(1) < count_reg)
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_HPRD;
                end
                else
                begin
                    idx_next = '0;
                    peak_next = '0;
                    state_next = nm_en_reg ? S_PKRD : S_STATUS;
                end
            end
            S_PKRD:
            begin
                state_next = S_PKCMP;
            end
            S_PKCMP:
            begin
                if (absv > peak_next)
                begin
                    peak_next = absv;
                end
                if (idx_reg + CW'(1) < count_reg)
                begin
                    idx_next = idx_reg + CW'(1);
                    ram_addr = idx_next[AW-1:0];
                    state_next = S_PKRD;
                end
                else
                begin
                    idx_next = '0;
                    ram_addr = '0;
                    state_next = (peak_next == '0) ? S_STATUS : S_NMRD;
                end
            end
            S_NMRD:
            begin
                state_next = S_NMDIV;
                x_next = '0;
            end
            S_NMDIV:
            begin
                if (x_reg == '0)
                begin
                    dreq.start = 1'b1;
                    dreq.dividend = {{4{sv[31]}}, sv, 28'd0};
                    dreq.divisor = 64'(peak_reg);
                    x_next = 32'(1);
                end
                else if (drsp.done)
                begin
                    prod_next = 49'(drsp.quotient);
                    mean_next = sat32(50'(drsp.quotient));
                    state_next = S_NMWR;
                end
            end
            S_NMWR:
            begin
                ram_we = 1'b1;
                ram_wdata = mean_reg;
                if (idx_reg + CW'(1) < count_reg)
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_NMRD;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_STATUS:
            begin
                res_v_next = 1'b1;
                res_next.kind = 1'b0;
                res_next.sample = '0;
                res_next.final_res = 1'b0;
                res_next.status = stat_code;
                res_next.frame_length = 13'(count_reg);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_next == S_NMRD || state_next == S_DCRD || state_next == S_HPRD)
        begin
            if (!ram_we)
            begin
                ram_addr = idx_next[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rptr_reg <= '0;
            idx_reg <= '0;
            err_reg <= '0;
            closed_reg <= 1'b0;
            sum_reg <= '0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rptr_reg <= rptr_next;
            idx_reg <= idx_next;
            err_reg <= err_next;
            closed_reg <= closed_next;
            sum_reg <= sum_next;
            res_v_reg <= res_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        px_reg <= px_next;
        py_reg <= py_next;
        peak_reg <= peak_next;
        prod_reg <= prod_next;
        x_reg <= x_next;
        res_reg <= res_next;
    end

    assign result_valid = res_v_reg;
    assign result = res_reg;

    // Status results carry no sample and never come with width error plus samples.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v_reg && !res_reg.kind) |-> (res_reg.sample == '0))
        else $error("status result with sample");
    a_width_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v_reg && !res_reg.kind && res_reg.status == afp_pkg::STATUS_WIDTH)
        |-> res_reg.frame_length == '0) else $error("width error with samples");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(afp_pkg::FRAME_DEPTH)) else $error("count overflow");
    a_read_closed: assert property (@(posedge clk) disable iff (!rst_n)
        (res_v_reg && res_reg.kind) |-> closed_reg) else $error("read of open frame");

endmodule

### rtl/afp_ram.sv
// Generic single-port RAM with registered read.
module afp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read at one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/afp_div.sv
// Shared restoring divider: signed dividend by positive divisor, quotient truncated to zero.
module afp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  afp_pkg::div_req_t req,
    output afp_pkg::div_rsp_t rsp
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    // One quotient bit per cycle.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        if (req.start)
        begin
            neg_next = req.dividend[63];
            quo_next = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
            rem_next = '0;
            den_next = req.divisor;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    // The divider never reports done while still counting.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("divider did not start");
    a_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == 7'd1 && !req.start) |=> done_reg)
        else $error("divider missed its last step");

endmodule
